// ===== rtl/core/kth_smallest_select_assert.svh =====
// ----------------------------------------------------------------------------
// kth_smallest_select assertion macros
// Shared property macros; expect clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef KTH_SMALLEST_SELECT_ASSERT_SVH
`define KTH_SMALLEST_SELECT_ASSERT_SVH

// same-cycle implication
`define KSEL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kth_smallest_select: same-cycle check failed");

// next-cycle implication
`define KSEL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kth_smallest_select: next-cycle check failed");

`endif

// ===== rtl/core/ksel_pkg.sv =====
// ----------------------------------------------------------------------------
// ksel_pkg
// Shared types and constants for the k-th smallest selector.
// ----------------------------------------------------------------------------
package ksel_pkg;

    localparam int VAL_W  = 32;
    localparam int RANK_W = 9;
    localparam int STAT_W = 2;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [STAT_W-1:0]       stat_t;

    localparam stat_t STAT_OK       = 2'd0;
    localparam stat_t STAT_BAD_RANK = 2'd1;
    localparam stat_t STAT_OVERFLOW = 2'd2;

    // broadcast control for the cell chain
    typedef struct packed {
        logic ins;    // insert key into the ordered chain
        logic shift;  // move every value one cell toward cell 0
        val_t key;
    } ksel_ctl_t;

endpackage

// ===== rtl/core/kth_smallest_select.sv =====
// ----------------------------------------------------------------------------
// kth_smallest_select
// Streams a signed data set into an ordered cell chain and returns the
// k-th smallest value after the last item arrives.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                  Fields                   Dir
//  item     item_valid/item_stall      value, last_item, rank   in
//  result   result_valid/result_stall  kth_value, status        out
//
//  A non-last item is sorted into the chain on its accept edge. A last item is too;
//  then the chain shifts toward cell 0 until the k-th smallest is in cell 0, and cell 0
//  loads the output register once it is free; an error status skips the shifts.
//  item_stall is high from the accept edge of a last item until that load.
//  A new set streams in while a result waits; the next load waits for the register.
//  Reset clears the control state; chain contents need no reset.
//
// ----------------------------------------------------------------------------
module kth_smallest_select
    import ksel_pkg::*;
#(
    parameter int MAX_ITEMS = 256
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    last_item,
    input  logic [RANK_W-1:0]       rank,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic signed [VAL_W-1:0] kth_value,
    output logic [STAT_W-1:0]       status
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEEK = 1'b1;

    logic              state_reg,  state_next;
    logic [CW-1:0]     count_reg,  count_next;
    logic              ovf_reg,    ovf_next;
    logic [RANK_W-1:0] shift_reg,  shift_next;
    stat_t             pend_reg,   pend_next;
    logic              rvalid_reg, rvalid_next;
    val_t              rvalue_reg, rvalue_next;
    stat_t             rstat_reg,  rstat_next;

    logic          item_acc;
    logic          full;
    logic [CW-1:0] count_after;
    logic          ovf_after;
    logic          rank_ok;
    logic          out_free;
    ksel_ctl_t     ctl;

    logic [MAX_ITEMS-1:0] occ;
    logic [MAX_ITEMS-1:0] gt;
    val_t                 cval [MAX_ITEMS];

    assign item_stall = (state_reg != ST_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign full       = (count_reg == CW'(MAX_ITEMS));
    assign ovf_after  = ovf_reg || full;
    assign count_after = full ? count_reg : count_reg + CW'(1);
    assign rank_ok    = (rank != '0) && (32'(rank) <= 32'(count_after));
    assign out_free   = !rvalid_reg || !result_stall;

    assign ctl.ins   = item_acc && !full;
    assign ctl.shift = (state_reg == ST_SEEK) && (shift_reg != '0);
    assign ctl.key   = value;

    // ordered chain, cell 0 holds the smallest
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        assign occ[i] = (CW'(i) < count_reg);

        ksel_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .occ      (occ[i]),
            .prev_gt  ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
            .prev_val ((i == 0) ? value : cval[(i == 0) ? 0 : i - 1]),
            .next_val ((i == MAX_ITEMS - 1) ? cval[i]
                                            : cval[(i == MAX_ITEMS - 1) ? i : i + 1]),
            .gt       (gt[i]),
            .val      (cval[i])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        shift_next  = shift_reg;
        pend_next   = pend_reg;
        rvalid_next = rvalid_reg && result_stall;
        rvalue_next = rvalue_reg;
        rstat_next  = rstat_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (last_item)
                    begin
                        // set closes: pick status, count shifts, start a new set
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_SEEK;
                        if (ovf_after)
                        begin
                            pend_next  = STAT_OVERFLOW;
                            shift_next = '0;
                        end
                        else if (!rank_ok)
                        begin
                            pend_next  = STAT_BAD_RANK;
                            shift_next = '0;
                        end
                        else
                        begin
                            pend_next  = STAT_OK;
                            shift_next = rank - RANK_W'(1);
                        end
                    end
                    else
                    begin
                        count_next = count_after;
                        ovf_next   = ovf_after;
                    end
                end
            end
            ST_SEEK:
            begin
                if (shift_reg != '0)
                begin
                    shift_next = shift_reg - RANK_W'(1);
                end
                else if (out_free)
                begin
                    rvalid_next = 1'b1;
                    rvalue_next = (pend_reg == STAT_OK) ? cval[0] : '0;
                    rstat_next  = pend_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            shift_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            shift_reg  <= shift_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        rvalue_reg <= rvalue_next;
        rstat_reg  <= rstat_next;
    end

    assign result_valid = rvalid_reg;
    assign kth_value    = rvalue_reg;
    assign status       = rstat_reg;

endmodule

// ===== rtl/core/ksel_cell.sv =====
// ----------------------------------------------------------------------------
// ksel_cell
// One slot of the ordered insertion chain.
// ----------------------------------------------------------------------------
module ksel_cell
    import ksel_pkg::*;
(
    input  logic      clk,
    input  ksel_ctl_t ctl,
    input  logic      occ,       // slot holds a value of the current set
    input  logic      prev_gt,   // left neighbor holds a value above key
    input  val_t      prev_val,
    input  val_t      next_val,
    output logic      gt,
    output val_t      val
);

    val_t val_reg;
    val_t val_next;

    assign gt  = occ && (val_reg > ctl.key);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.shift)
        begin
            val_next = next_val;
        end
        else if (ctl.ins)
        begin
            if (prev_gt)
            begin
                val_next = prev_val;     // make room: take neighbor's value
            end
            else if (!occ || gt)
            begin
                val_next = ctl.key;      // insertion point
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== rtl/core/ksel_check.sv =====
// ----------------------------------------------------------------------------
// ksel_check
// Port-level checks for kth_smallest_select, bound to the top level.
// ----------------------------------------------------------------------------
`include "kth_smallest_select_assert.svh"

module ksel_check
    import ksel_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    item_valid,
    input logic                    item_stall,
    input logic                    last_item,
    input logic                    result_valid,
    input logic                    result_stall,
    input logic signed [VAL_W-1:0] kth_value,
    input logic [STAT_W-1:0]       status
);

    `KSEL_ASSERT_NOW(a_stat_code, result_valid, status <= STAT_OVERFLOW)
    `KSEL_ASSERT_NOW(a_err_zero, result_valid && (status != STAT_OK), kth_value == '0)
    `KSEL_ASSERT_NEXT(a_search_stalls, item_valid && !item_stall && last_item, item_stall)
    `KSEL_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid && $stable(kth_value) && $stable(status))

endmodule

bind kth_smallest_select ksel_check u_ksel_check (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// kth_smallest_select testbench
// Streams signed data sets into the selector and checks every k-th smallest
// answer and status against an ordered-set predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
module testbench;
    import ksel_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 256;
    // Slowest legal run: about 800 items under heavy idling, one search per
    // set, result stalls and the long hold-off. This is several times that.
    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 300;   // a full 256-deep search plus margin
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    localparam val_t VAL_MIN = 32'sh8000_0000;
    localparam val_t VAL_MAX = 32'sh7fff_ffff;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps the current set in ascending order as it arrives and
    // queues one answer per last-item transaction.
    // ------------------------------------------------------------------------
    class rank_scoreboard;
        typedef struct {
            val_t  kth;
            stat_t st;
        } answer_t;

        val_t    sorted_set[$];
        bit      set_overflow;
        answer_t answers_due[$];
        int      n_sets, n_ok, n_bad_rank, n_overflow, n_results, n_fail;

        function void note_item(val_t v, logic last, logic [RANK_W-1:0] k);
            answer_t ans;
            int      lo;
            int      hi;
            int      mid;
            if (sorted_set.size() >= STORE_DEPTH)
            begin
                set_overflow = 1'b1;
            end
            else
            begin
                // upper bound: equal values keep arrival order
                lo = 0;
                hi = sorted_set.size();
                while (lo < hi)
                begin
                    mid = (lo + hi) / 2;
                    if (sorted_set[mid] <= v)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                sorted_set.insert(lo, v);
            end
            if (!last)
                return;
            ans.kth = '0;
            if (set_overflow)
            begin
                ans.st = STAT_OVERFLOW;
                n_overflow++;
            end
            else if (k == 0 || k > sorted_set.size())
            begin
                ans.st = STAT_BAD_RANK;
                n_bad_rank++;
            end
            else
            begin
                ans.st  = STAT_OK;
                ans.kth = sorted_set[k - 1];
                n_ok++;
            end
            answers_due.push_back(ans);
            sorted_set.delete();
            set_overflow = 1'b0;
            n_sets++;
        endfunction

        function void check_result(val_t got_kth, stat_t got_st);
            answer_t ans;
            n_results++;
            if (answers_due.size() == 0)
            begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("mismatch: result with nothing expected, kth=%0d status=%0d",
                             got_kth, got_st);
                return;
            end
            ans = answers_due.pop_front();
            if (got_kth !== ans.kth || got_st !== ans.st)
            begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("mismatch %0d: kth exp %0d got %0d, status exp %0d got %0d",
                             n_results, ans.kth, got_kth, ans.st, got_st);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_stall;
    val_t                    value;
    logic                    last_item;
    logic [RANK_W-1:0]       rank;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    val_t                    kth_value;
    stat_t                   status;

    rank_scoreboard sb;

    int send_idle_pct  = 0;   // chance per cycle that the sender holds back
    int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
    bit hold_off       = 1'b0; // long receiver hold-off, written on posedge only
    int cycle_count    = 0;

    kth_smallest_select #(
        .MAX_ITEMS    (STORE_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .value        (value),
        .last_item    (last_item),
        .rank         (rank),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kth_value    (kth_value),
        .status       (status)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, sb.answers_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: stall changes on the falling edge only. The hold-off flag is
    // toggled on rising edges, so reading it here never races.
    always @(negedge clk)
    begin
        result_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // Result monitor: a transaction completes at a rising edge with valid
    // high and stall low; values are those from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(kth_value, status);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Entered and left at a falling edge. Valid stays high straight into the
    // next item when the caller sends again without idling.
    task automatic send_item(val_t v, logic last, logic [RANK_W-1:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        last_item  <= last;
        rank       <= k;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(v, last, k);
        @(negedge clk);
    endtask

    task automatic send_list(val_t vals[$], logic [RANK_W-1:0] k);
        for (int i = 0; i < vals.size(); i++)
            send_item(vals[i], i == vals.size() - 1, k);
    endtask

    // Full-width random values mixed with a narrow band (duplicates) and
    // the two extremes.
    function automatic val_t rand_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return val_t'($urandom);
        else if (sel < 80)
            return val_t'(int'($urandom_range(16)) - 8);
        else if (sel < 90)
            return VAL_MIN;
        else
            return VAL_MAX;
    endfunction

    // Mostly a valid rank; otherwise zero, one past the end, or any 9-bit code.
    function automatic logic [RANK_W-1:0] pick_rank(int n);
        int sel;
        sel = $urandom_range(99);
        if (sel < 80)
            return RANK_W'($urandom_range(n, 1));
        else if (sel < 86)
            return '0;
        else if (sel < 92)
            return RANK_W'(n + 1);
        else
            return RANK_W'($urandom_range(511, 0));
    endfunction

    task automatic send_random_set(int n, logic [RANK_W-1:0] k);
        for (int i = 0; i < n; i++)
            send_item(rand_value(), i == n - 1, k);
    endtask

    // Small sets mostly, an occasional medium one.
    task automatic send_random_sets(int n_items);
        int sent;
        int sz;
        sent = 0;
        while (sent < n_items)
        begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            send_random_set(sz, pick_rank(sz));
            sent += sz;
        end
    endtask

    // Sender goes quiet until every answer owed has been taken.
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.answers_due.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb         = new();
        rst_n      = 1'b0;
        item_valid = 1'b0;
        value      = '0;
        last_item  = 1'b0;
        rank       = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, duplicates, bad-rank cases, smallest/largest.
        send_list('{VAL_MIN}, 9'd1);
        send_list('{VAL_MAX}, 9'd1);
        send_list('{VAL_MAX, VAL_MIN, 32'sd0, -32'sd1, 32'sd1}, 9'd5);
        send_list('{32'sd7, 32'sd7, -32'sd7}, 9'd2);
        send_list('{32'sd42}, 9'd0);               // rank zero
        send_list('{32'sd1, 32'sd2}, 9'd3);        // rank past the count
        send_list('{32'sd9}, 9'd511);              // every rank bit set
        send_list('{-32'sd1, -32'sd1, -32'sd1, -32'sd2}, 9'd4);
        send_list('{VAL_MIN, VAL_MIN}, 9'd256);
        drain();

        // Store-sized sets: full store with the top rank, then a set that
        // overflows before and on its last item with rank zero (overflow
        // beats a bad rank).
        send_random_set(STORE_DEPTH, 9'd256);
        send_random_set(STORE_DEPTH + 2, 9'd0);
        drain();

        // Random phases with different idling on each side.
        send_idle_pct = 0;  recv_stall_pct = 0;
        send_random_sets(60);
        drain();
        send_idle_pct = 74; recv_stall_pct = 0;
        send_random_sets(60);
        drain();
        send_idle_pct = 0;  recv_stall_pct = 74;
        send_random_sets(60);
        drain();
        send_idle_pct = 19; recv_stall_pct = 19;
        send_random_sets(60);
        drain();

        // Back-pressure: hold the result side off while sets keep coming,
        // so the output register fills and the next search blocks the input.
        send_idle_pct = 0;  recv_stall_pct = 0;
        fork
            begin
                @(posedge clk);
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            send_random_sets(40);
        join
        drain();

        // Quiet tail: catches any result that nobody asked for.
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("%0d sets (%0d ok, %0d bad rank, %0d overflow), %0d results in %0d cycles",
                 sb.n_sets, sb.n_ok, sb.n_bad_rank, sb.n_overflow, sb.n_results, cycle_count);
        $display("idling phases none/sender/receiver/both plus a %0d-cycle hold-off; %0d failures",
                 HOLD_CYCLES, sb.n_fail);
        if (sb.n_fail == 0 && sb.answers_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
